[hw/rtl/dri_pkg.sv]
package dri_pkg;

  localparam logic [32:0] KANG  = 33'd341782638;
  localparam logic [33:0] KGAIN = 34'd652032874;

  typedef struct packed {
    logic               start_flag;
    logic signed [15:0] speed;
    logic signed [15:0] turn_rate;
    logic [31:0]        sample_time;
  } dri_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
  } dri_out_t;

  typedef enum logic [2:0] {
    MUL_YAW_DT,
    MUL_SPD_DT,
    MUL_P_LO,
    MUL_P_HI,
    MUL_COS,
    MUL_SIN
  } dri_mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_YAW,
    S_MUL_SPD,
    S_MUL_KLO,
    S_MUL_KHI,
    S_HEAD,
    S_CORDIC_INIT,
    S_CORDIC,
    S_MUL_COS,
    S_MUL_SIN,
    S_ACC_X,
    S_ACC_Y,
    S_DONE
  } dri_state_e;

  typedef struct packed {
    logic         load;
    logic         mul_en;
    dri_mul_sel_e mul_sel;
    logic         st_p;
    logic         st_travel;
    logic         st_klo;
    logic         st_head;
    logic         cordic_init;
    logic         cordic_step;
    logic         st_d;
    logic         acc_x;
    logic         acc_y;
    logic         out_load;
  } dri_cmd_t;

  typedef struct packed {
    logic start;
    logic cordic_last;
  } dri_sts_t;

  // atan(2^-i) as a binary angle, full turn is 2^32
  function automatic logic [31:0] dri_atan(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/dri_stream_if.sv]
interface dri_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/dri_ctrl.sv]
module dri_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dri_pkg::dri_sts_t sts_i,
  output dri_pkg::dri_cmd_t cmd_o
);
  import dri_pkg::*;

  dri_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_YAW_DT;
    in_ready_o    = 1'b0;
    out_valid_d   = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.start ? S_DONE : S_MUL_YAW;
        end
      end
      S_MUL_YAW: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_YAW_DT;
        state_d       = S_MUL_SPD;
      end
      S_MUL_SPD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SPD_DT;
        cmd_o.st_p    = 1'b1;
        state_d       = S_MUL_KLO;
      end
      S_MUL_KLO: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_P_LO;
        cmd_o.st_travel = 1'b1;
        state_d         = S_MUL_KHI;
      end
      S_MUL_KHI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P_HI;
        cmd_o.st_klo  = 1'b1;
        state_d       = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.st_head = 1'b1;
        state_d       = S_CORDIC_INIT;
      end
      S_CORDIC_INIT: begin
        cmd_o.cordic_init = 1'b1;
        state_d           = S_CORDIC;
      end
      S_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_last) begin
          state_d = S_MUL_COS;
        end
      end
      S_MUL_COS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_COS;
        state_d       = S_MUL_SIN;
      end
      S_MUL_SIN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SIN;
        cmd_o.st_d    = 1'b1;
        state_d       = S_ACC_X;
      end
      S_ACC_X: begin
        cmd_o.acc_x = 1'b1;
        cmd_o.st_d  = 1'b1;
        state_d     = S_ACC_Y;
      end
      S_ACC_Y: begin
        cmd_o.acc_y = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending item");

  a_start_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts_i.start) |=> (state_q == S_DONE))
    else $error("trajectory start did not skip the datapath");

  a_cordic_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORDIC && sts_i.cordic_last) |=> (state_q == S_MUL_COS))
    else $error("cordic did not hand over to the multiplier");

  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not shown");

endmodule

[hw/rtl/dri_dpath.sv]
module dri_dpath #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dri_pkg::dri_in_t  in_i,
  input  dri_pkg::dri_cmd_t cmd_i,
  output dri_pkg::dri_sts_t sts_o,
  output dri_pkg::dri_out_t out_o
);
  import dri_pkg::*;

  localparam int CntW = $clog2(CORDIC_STEPS);

  logic [31:0]        last_time_q;
  logic [31:0]        heading_q;
  logic signed [31:0] x_acc_q, y_acc_q;

  logic [31:0]        delta_q;
  logic signed [15:0] speed_q, turn_q;
  logic [48:0]        p_q;
  logic signed [32:0] travel_q;
  logic [31:0]        klo_q;
  logic signed [65:0] prod_q;
  logic signed [35:0] d_q;
  logic signed [33:0] cx_q, cy_q, z_q;
  logic               flip_q;
  logic [CntW-1:0]    cnt_q;
  dri_out_t           out_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [33:0] cos_w, sin_w;
  logic signed [49:0] tr_sum;
  logic signed [65:0] rn_sum;
  logic [65:0]        k_sum;
  logic [31:0]        ang_plus, ang_fold;
  logic               fold;
  logic signed [33:0] atan_w;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                input logic signed [35:0] d);
    logic signed [36:0] s;
    logic signed [31:0] r;
    s = 37'(acc) + 37'(d);
    if (s > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (s < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  assign cos_w = flip_q ? -cx_q : cx_q;
  assign sin_w = flip_q ? -cy_q : cy_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_YAW_DT: begin
        mul_a = 33'(turn_q);
        mul_b = $signed({1'b0, delta_q});
      end
      MUL_SPD_DT: begin
        mul_a = 33'(speed_q);
        mul_b = $signed({1'b0, delta_q});
      end
      MUL_P_LO: begin
        mul_a = $signed({1'b0, p_q[31:0]});
        mul_b = $signed(KANG);
      end
      MUL_P_HI: begin
        mul_a = $signed({{16{p_q[48]}}, p_q[48:32]});
        mul_b = $signed(KANG);
      end
      MUL_COS: begin
        mul_a = travel_q;
        mul_b = cos_w[32:0];
      end
      MUL_SIN: begin
        mul_a = travel_q;
        mul_b = sin_w[32:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round half away from zero: add half, minus one for negative values, then floor
  assign tr_sum = $signed({prod_q[48], prod_q[48:0]}) + 50'sd32767
                + $signed({49'd0, ~prod_q[48]});
  assign rn_sum = prod_q + 66'sd536870911 + $signed({65'd0, ~prod_q[65]});
  assign k_sum  = prod_q + 66'sd2147483648;

  assign ang_plus = heading_q + 32'h4000_0000;
  assign fold     = ang_plus[31];
  assign ang_fold = fold ? heading_q + 32'h8000_0000 : heading_q;
  assign atan_w   = $signed({2'b00, dri_atan(5'(cnt_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      heading_q   <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        last_time_q <= in_i.sample_time;
        if (in_i.start_flag) begin
          heading_q <= '0;
          x_acc_q   <= '0;
          y_acc_q   <= '0;
        end
      end
      if (cmd_i.st_head) begin
        heading_q <= heading_q + klo_q + prod_q[31:0];
      end
      if (cmd_i.acc_x) begin
        x_acc_q <= sat_add(x_acc_q, d_q);
      end
      if (cmd_i.acc_y) begin
        y_acc_q <= sat_add(y_acc_q, d_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      delta_q <= in_i.sample_time - last_time_q;
      speed_q <= in_i.speed;
      turn_q  <= in_i.turn_rate;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.st_p) begin
      p_q <= prod_q[48:0];
    end
    if (cmd_i.st_travel) begin
      travel_q <= tr_sum[48:16];
    end
    if (cmd_i.st_klo) begin
      klo_q <= k_sum[63:32];
    end
    if (cmd_i.st_d) begin
      d_q <= rn_sum[65:30];
    end
    if (cmd_i.cordic_init) begin
      cx_q   <= $signed(KGAIN);
      cy_q   <= '0;
      z_q    <= 34'($signed(ang_fold));
      flip_q <= fold;
      cnt_q  <= '0;
    end else if (cmd_i.cordic_step) begin
      if (!z_q[33]) begin
        cx_q <= cx_q - (cy_q >>> cnt_q);
        cy_q <= cy_q + (cx_q >>> cnt_q);
        z_q  <= z_q - atan_w;
      end else begin
        cx_q <= cx_q + (cy_q >>> cnt_q);
        cy_q <= cy_q - (cx_q >>> cnt_q);
        z_q  <= z_q + atan_w;
      end
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_q.pos_x   <= x_acc_q;
      out_q.pos_y   <= y_acc_q;
      out_q.heading <= heading_q;
    end
  end

  assign sts_o.start       = in_i.start_flag;
  assign sts_o.cordic_last = (cnt_q == CntW'(CORDIC_STEPS - 1));
  assign out_o             = out_q;

endmodule

[hw/rtl/dead_reckoning_pose_integrator_unit.sv]
// a normal sample passes the yaw, speed and scale multiplies, the heading update, the
// one-step-a-cycle cordic, the cos and sin multiplies and the x and y sums before its pose
// is loaded: six passes through the shared 33x33 multiplier; the next sample waits for idle
// a trajectory start sample skips the datapath and shows a zero pose
// a new sample is accepted while the previous pose still waits on the output
// reset (rst_ni low, asynchronous) clears time, heading and position to zero
module dead_reckoning_pose_integrator_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dri_stream_if.sink   sample_i,
  dri_stream_if.source pose_o
);
  import dri_pkg::*;

  dri_cmd_t cmd;
  dri_sts_t sts;
  dri_in_t  in_data;
  dri_out_t out_data;

  assign in_data = sample_i.payload;

  dri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (pose_o.valid),
    .out_ready_i (pose_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dri_dpath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_data),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_data)
  );

  assign pose_o.payload = out_data;

endmodule

[tb/sv/dead_reckoning_pose_integrator_unit_tb.sv]
`timescale 1ns / 100ps

module dead_reckoning_pose_integrator_unit_tb;
  import dri_pkg::*;

  localparam int          ROT_STEPS   = 16;
  localparam int          N_SAMPLES   = 1850;
  localparam int          IDLE_PCT    = 21;
  localparam int          QUIET_LO    = 800;
  localparam int          QUIET_HI    = 1100;
  localparam int          DRAIN_EVERY = 500;
  localparam logic [63:0] TURN_SCALE  = 64'd341782638;
  localparam longint      ROT_GAIN    = 652032874;

  typedef struct packed {
    logic    drain;
    dri_in_t smp;
  } pending_smp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dri_stream_if #(.payload_t(dri_in_t))  sample_if ();
  dri_stream_if #(.payload_t(dri_out_t)) pose_if ();

  dead_reckoning_pose_integrator_unit #(
    .CORDIC_STEPS(ROT_STEPS)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .pose_o  (pose_if)
  );

  always #6 clk_i = ~clk_i;

  // rotation angles atan(2^-i), full turn is 2^32
  logic [31:0] rot_angle [30] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  pending_smp_t stim_q[$];
  dri_out_t     pose_exp[$];
  int           smp_cnt  = 0;
  int           pose_cnt = 0;
  int           fail_cnt = 0;

  // tracked vehicle state
  logic [31:0] prev_time = '0;
  logic [31:0] pose_head = '0;
  logic [31:0] pose_x    = '0;
  logic [31:0] pose_y    = '0;

  function automatic longint round_away(input longint v, input int unsigned sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] acc, input longint d);
    longint s;
    s = longint'(signed'(acc)) + d;
    if (s > longint'(32'sh7FFF_FFFF)) s = longint'(32'sh7FFF_FFFF);
    if (s < longint'(32'sh8000_0000)) s = longint'(32'sh8000_0000);
    return s[31:0];
  endfunction

  // cos and sin in Q2.30 by rotation, angle folded into the right half plane
  task automatic unit_vector(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] a;
    logic        fold;
    longint      x, y, z, nx;
    a    = ang;
    fold = 1'b0;
    if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      a    = a + 32'h8000_0000;
      fold = 1'b1;
    end
    z = longint'(signed'(a));
    x = ROT_GAIN;
    y = 0;
    for (int i = 0; i < ROT_STEPS && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(rot_angle[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(rot_angle[i]);
      end
      x = nx;
    end
    c = fold ? -x : x;
    s = fold ? -y : y;
  endtask

  task automatic advance_pose(input dri_in_t smp, output dri_out_t pose);
    logic [31:0] dt;
    logic [63:0] turn_prod;
    longint      travel, cs, sn;
    if (smp.start_flag) begin
      pose_x    = '0;
      pose_y    = '0;
      pose_head = '0;
    end else begin
      dt        = smp.sample_time - prev_time;
      turn_prod = 64'(longint'(smp.turn_rate) * longint'({32'd0, dt}));
      turn_prod = turn_prod * TURN_SCALE + 64'h8000_0000;
      pose_head = pose_head + turn_prod[63:32];
      travel    = round_away(longint'(smp.speed) * longint'({32'd0, dt}), 16);
      unit_vector(pose_head, cs, sn);
      pose_x    = sat_add32(pose_x, round_away(travel * cs, 30));
      pose_y    = sat_add32(pose_y, round_away(travel * sn, 30));
    end
    prev_time    = smp.sample_time;
    pose.pos_x   = pose_x;
    pose.pos_y   = pose_y;
    pose.heading = pose_head;
  endtask

  task automatic add_sample(input logic start, input logic [15:0] spd,
                            input logic [15:0] yaw, input logic [31:0] t,
                            input logic drain);
    pending_smp_t p;
    p.drain           = drain;
    p.smp.start_flag  = start;
    p.smp.speed       = spd;
    p.smp.turn_rate   = yaw;
    p.smp.sample_time = t;
    stim_q.insert(stim_q.size(), p);
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    dri_out_t nxt;
    logic     quiet;
    if (!rst_ni) begin
      sample_if.valid   <= 1'b0;
      sample_if.payload <= '0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        advance_pose(sample_if.payload, nxt);
        pose_exp.insert(pose_exp.size(), nxt);
        smp_cnt <= smp_cnt + 1;
      end
      quiet = (smp_cnt >= QUIET_LO) && (smp_cnt < QUIET_HI);
      if (!sample_if.valid || sample_if.ready) begin
        // a drain item waits until every pose has come back
        if (stim_q.size() != 0 && (!stim_q[0].drain || pose_exp.size() == 0) &&
            (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          sample_if.payload <= stim_q[0].smp;
          sample_if.valid   <= 1'b1;
          void'(stim_q.pop_front());
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // pose monitor
  always @(posedge clk_i or negedge rst_ni) begin
    dri_out_t want;
    logic     quiet;
    if (!rst_ni) begin
      pose_if.ready <= 1'b0;
    end else begin
      if (pose_if.valid && pose_if.ready) begin
        pose_cnt <= pose_cnt + 1;
        if (pose_exp.size() == 0) begin
          fail_cnt <= fail_cnt + 1;
          if (fail_cnt < 10)
            $display("unexpected pose: x %h y %h heading %h", pose_if.payload.pos_x,
                     pose_if.payload.pos_y, pose_if.payload.heading);
        end else begin
          want = pose_exp.pop_front();
          if (pose_if.payload.pos_x !== want.pos_x || pose_if.payload.pos_y !== want.pos_y ||
              pose_if.payload.heading !== want.heading) begin
            fail_cnt <= fail_cnt + 1;
            if (fail_cnt < 10)
              $display("pose %0d mismatch: x %h/%h y %h/%h heading %h/%h (exp/got)",
                       pose_cnt, want.pos_x, pose_if.payload.pos_x, want.pos_y,
                       pose_if.payload.pos_y, want.heading, pose_if.payload.heading);
          end
        end
      end
      quiet = (pose_cnt >= QUIET_LO) && (pose_cnt < QUIET_HI);
      pose_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    logic [31:0] t_now;
    logic [15:0] spd, yaw;
    int          len, pick, next_drain;
    rst_ni            = 1'b0;
    sample_if.valid   = 1'b0;
    sample_if.payload = '0;
    pose_if.ready     = 1'b0;

    // no start after reset, delta from time zero
    add_sample(1'b0, 16'sd256, 16'sd0, 32'h0010_0000, 1'b0);
    // start item with extreme fields, which are ignored
    add_sample(1'b1, 16'h8000, 16'h7FFF, 32'd100, 1'b0);
    add_sample(1'b0, 16'h7FFF, 16'h7FFF, 32'd100 + 32'h0010_0000, 1'b0);
    add_sample(1'b0, 16'h8000, 16'h8000, 32'd100 + 32'h0020_0000, 1'b0);
    // zero delta
    add_sample(1'b0, 16'h7FFF, 16'h7FFF, 32'd100 + 32'h0020_0000, 1'b0);
    add_sample(1'b0, 16'd0, 16'd0, 32'h0030_0000, 1'b0);
    // timestamp wraps forward, then goes backwards
    add_sample(1'b1, 16'h0000, 16'h0000, 32'hFFFF_FF00, 1'b0);
    add_sample(1'b0, 16'sd1000, 16'sd4096, 32'h0000_0100, 1'b0);
    add_sample(1'b0, 16'sd5, 16'sd3, 32'h0000_0050, 1'b0);
    // position saturation on x, both directions
    add_sample(1'b1, 16'h7FFF, 16'h8000, 32'd0, 1'b0);
    add_sample(1'b0, 16'h7FFF, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    add_sample(1'b0, 16'h7FFF, 16'h0000, 32'hFFFF_FFFE, 1'b0);
    add_sample(1'b0, 16'h8000, 16'h0000, 32'hFFFF_FFFD, 1'b0);
    add_sample(1'b0, 16'h8000, 16'h0000, 32'hFFFF_FFFC, 1'b0);
    add_sample(1'b0, 16'h8000, 16'h0000, 32'hFFFF_FFFB, 1'b0);
    add_sample(1'b0, 16'h8000, 16'h0000, 32'hFFFF_FFFA, 1'b0);
    // turn first, then drive hard along the new heading
    add_sample(1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    add_sample(1'b0, 16'h0000, 16'h8000, 32'h4000_0000, 1'b0);
    add_sample(1'b0, 16'h7FFF, 16'h0000, 32'h3FFF_FFFF, 1'b0);
    add_sample(1'b0, 16'h7FFF, 16'h0000, 32'h3FFF_FFFE, 1'b0);
    add_sample(1'b0, 16'h8000, 16'h1234, 32'h3FFF_FFFD, 1'b0);
    add_sample(1'b0, 16'h7FFF, 16'h7FFF, 32'h8000_0000, 1'b0);
    add_sample(1'b0, 16'hFFFF, 16'h0001, 32'h8000_0001, 1'b0);

    next_drain = stim_q.size();
    while (stim_q.size() < N_SAMPLES) begin
      if ($urandom_range(0, 99) < 8) begin
        // noise: any field value, start bit random
        add_sample(1'($urandom), 16'($urandom), 16'($urandom), $urandom, 1'b0);
      end else begin
        t_now = $urandom;
        add_sample(1'b1, 16'($urandom), 16'($urandom), t_now, stim_q.size() >= next_drain);
        if (stim_q.size() > next_drain) next_drain = next_drain + DRAIN_EVERY;
        len = $urandom_range(1, 40);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 85)      t_now = t_now + $urandom_range(0, 1 << 17);
          else if (pick < 93) t_now = t_now + $urandom_range(1 << 17, 1 << 24);
          else if (pick < 97) t_now = t_now + $urandom;
          else                t_now = t_now - $urandom_range(1, 1 << 16);
          spd = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5120) - 2560);
          yaw = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
          add_sample(1'b0, spd, yaw, t_now, 1'b0);
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || sample_if.valid) @(posedge clk_i);
    while (pose_exp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** dead_reckoning_pose_integrator_unit: PASSED **");
    end else begin
      $display("** dead_reckoning_pose_integrator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("** dead_reckoning_pose_integrator_unit: FAILED **");
    $finish;
  end

endmodule
